// File: rtl/pfdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfdm_pkg
// Shared types and constants of the PWM frequency and duty meter.
// ----------------------------------------------------------------------------
package pfdm_pkg;

	localparam int TICK_W  = 16;   // width of the tick count outputs
	localparam int FREQ_W  = 16;   // width of the kHz output
	localparam int DUTY_W  = 7;    // width of the percent output
	localparam int CLK_W   = 27;   // width of the tick rate register

	localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET = 27'd16000000;
	localparam logic [FREQ_W-1:0] FREQ_MAX       = 16'hFFFF;
	localparam int                HZ_PER_KHZ     = 1000;
	localparam int                PERCENT        = 100;
	localparam int                KHZ_W          = 10;  // bits of HZ_PER_KHZ
	localparam int                PERCENT_W      = 7;   // bits of PERCENT

	// register word indexes
	localparam logic REG_CLOCK_HZ = 1'b0;

	// controller to datapath
	typedef struct packed {
		logic step;        // item accepted: advance counter, track level
		logic cap_a;       // capture first rising edge
		logic cap_b;       // capture falling edge
		logic cap_c;       // capture second rising edge, form high and period
		logic start_freq;  // start tick rate / (period * 1000)
		logic save_freq;   // keep the saturated frequency quotient
		logic start_duty;  // start (100 * high) / period
		logic load_out;    // fill the output register
		logic restart;     // clear the measurement
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rising;
		logic falling;
		logic ok;          // registered: captures strictly increased
		logic div_idle;
	} status_t;

endpackage
`default_nettype wire

// File: rtl/pwm_frequency_duty_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_frequency_duty_meter
// Input-capture meter: high time, period, frequency in kHz and duty percent.
// ----------------------------------------------------------------------------
// Feed one sampled pin level per timer tick on the input channel. While the
// meter looks for the first rising edge, the falling edge and the closing
// rising edge it takes one item every cycle. After the closing edge it stops
// taking items: the PREP state checks the captures, then a shared restoring
// divider that yields one quotient bit per cycle runs twice, first for tick
// rate / (period * 1000) and then for (100 * high) / period, and the HOLD
// state moves the result into the output register. An out-of-range
// measurement skips the divider and goes from PREP straight to HOLD. HOLD
// stays while an earlier result still waits in the output register. The
// meter then restarts with the counter at zero and the previous level taken
// as high, so a new measurement needs a low sample before its first rising
// edge. The tick counter wraps silently; wrapped captures normally show up
// as out of range with every value zeroed. Program the tick rate (clock_hz,
// word 0 of the APB space) only while the meter is idle.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_meter #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// sample channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        pin_level,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             in_range,
	output logic [pfdm_pkg::TICK_W-1:0]      high_ticks,
	output logic [pfdm_pkg::TICK_W-1:0]      period_ticks,
	output logic [pfdm_pkg::FREQ_W-1:0]      freq_khz,
	output logic [pfdm_pkg::DUTY_W-1:0]      duty_percent,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [pfdm_pkg::CLK_W-1:0] clock_hz_q;
	logic                       reg_hit;
	pfdm_pkg::cmd_t             cmd;
	pfdm_pkg::status_t          st;

	// Decode the single register; any other word reads as zero.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == pfdm_pkg::REG_CLOCK_HZ);
	assign prdata  = reg_hit ? 32'(clock_hz_q) : '0;

	// Write on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= pfdm_pkg::CLOCK_HZ_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			clock_hz_q <= pwdata[pfdm_pkg::CLK_W-1:0];
		end
	end

	// Sequence edge phases, divisions and the handoff to the output register.
	pfdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Hold the counter, captures, divider and result fields.
	pfdm_dp #(
		.CW (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.pin_level    (pin_level),
		.clock_hz     (clock_hz_q),
		.cmd          (cmd),
		.st           (st),
		.in_range     (in_range),
		.high_ticks   (high_ticks),
		.period_ticks (period_ticks),
		.freq_khz     (freq_khz),
		.duty_percent (duty_percent)
	);

	// Never take a sample while the divider is working.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && !st.div_idle))
		else $error("sample taken while divider busy");

	// Never overwrite a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	// Zero every value of an out-of-range result.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_range) |-> (high_ticks == '0 && period_ticks == '0
			&& freq_khz == '0 && duty_percent == '0))
		else $error("out-of-range result carries values");

	// Keep duty within a full period.
	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_range) |-> (duty_percent < 7'(pfdm_pkg::PERCENT)))
		else $error("duty percent out of bound");

endmodule
`default_nettype wire

// File: rtl/pfdm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfdm_ctrl
// Measurement sequencer: edge phases, division steps and output handoff.
// ----------------------------------------------------------------------------
module pfdm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire pfdm_pkg::status_t st,
	output pfdm_pkg::cmd_t        cmd
);

	localparam logic [2:0] S_RISE1 = 3'd0;
	localparam logic [2:0] S_FALL  = 3'd1;
	localparam logic [2:0] S_RISE2 = 3'd2;
	localparam logic [2:0] S_PREP  = 3'd3;
	localparam logic [2:0] S_DIVF  = 3'd4;
	localparam logic [2:0] S_DIVD  = 3'd5;
	localparam logic [2:0] S_HOLD  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       acc;

	assign in_ready  = (state_q == S_RISE1) || (state_q == S_FALL) || (state_q == S_RISE2);
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cmd.step = acc;
		unique case (state_q)
			S_RISE1: begin
				if (acc && st.rising) begin
					cmd.cap_a = 1'b1;
					state_d   = S_FALL;
				end
			end
			S_FALL: begin
				if (acc && st.falling) begin
					cmd.cap_b = 1'b1;
					state_d   = S_RISE2;
				end
			end
			S_RISE2: begin
				if (acc && st.rising) begin
					cmd.cap_c = 1'b1;
					state_d   = S_PREP;
				end
			end
			S_PREP: begin
				if (st.ok) begin
					cmd.start_freq = 1'b1;
					state_d        = S_DIVF;
				end else begin
					state_d = S_HOLD;
				end
			end
			S_DIVF: begin
				if (st.div_idle) begin
					cmd.save_freq  = 1'b1;
					cmd.start_duty = 1'b1;
					state_d        = S_DIVD;
				end
			end
			S_DIVD: begin
				if (st.div_idle) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					cmd.restart  = 1'b1;
					state_d      = S_RISE1;
				end
			end
			default: begin
				state_d = S_RISE1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RISE1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/pfdm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfdm_dp
// Tick counter, edge captures, shared restoring divider and output register.
// ----------------------------------------------------------------------------
module pfdm_dp #(
	parameter int CW = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pin_level,
	input  wire logic [pfdm_pkg::CLK_W-1:0]     clock_hz,
	input  wire pfdm_pkg::cmd_t                 cmd,
	output pfdm_pkg::status_t                   st,
	output logic                                in_range,
	output logic [pfdm_pkg::TICK_W-1:0]         high_ticks,
	output logic [pfdm_pkg::TICK_W-1:0]         period_ticks,
	output logic [pfdm_pkg::FREQ_W-1:0]         freq_khz,
	output logic [pfdm_pkg::DUTY_W-1:0]         duty_percent
);

	localparam int NW  = (CW + pfdm_pkg::PERCENT_W > pfdm_pkg::CLK_W) ?
		(CW + pfdm_pkg::PERCENT_W) : pfdm_pkg::CLK_W;   // dividend width
	localparam int DV  = CW + pfdm_pkg::KHZ_W;          // divisor width
	localparam int CNW = $clog2(NW + 1);
	localparam logic [CNW-1:0] STEPS = CNW'(NW);

	logic [CW-1:0] tick_q, first_q, fall_q, high_q, per_q;
	logic          last_q, ok_q;
	logic [pfdm_pkg::FREQ_W-1:0] freq_q;

	logic [DV-1:0]  rem_q, dvs_q;
	logic [NW-1:0]  dvd_q;
	logic [CNW-1:0] cnt_q;
	logic [DV:0]    shl, diff;
	logic           ge;

	assign st.rising   = !last_q && pin_level;
	assign st.falling  = last_q && !pin_level;
	assign st.ok       = ok_q;
	assign st.div_idle = (cnt_q == '0);

	// one quotient bit a cycle
	assign shl  = {rem_q, dvd_q[NW-1]};
	assign diff = shl - {1'b0, dvs_q};
	assign ge   = (shl >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			last_q <= 1'b1;
			cnt_q  <= '0;
		end else begin
			if (cmd.restart) begin
				tick_q <= '0;
				last_q <= 1'b1;
			end else if (cmd.step) begin
				tick_q <= tick_q + CW'(1);
				last_q <= pin_level;
			end
			if (cmd.start_freq || cmd.start_duty) begin
				cnt_q <= STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			first_q <= tick_q;
		end
		if (cmd.cap_b) begin
			fall_q <= tick_q;
		end
		if (cmd.cap_c) begin
			high_q <= fall_q - first_q;
			per_q  <= tick_q - first_q;
			ok_q   <= (first_q < fall_q) && (fall_q < tick_q);
		end
		if (cmd.start_freq) begin
			// floor(floor(x / p) / 1000) equals floor(x / (p * 1000))
			rem_q <= '0;
			dvd_q <= NW'(clock_hz);
			dvs_q <= DV'(per_q) * DV'(pfdm_pkg::HZ_PER_KHZ);
		end else if (cmd.start_duty) begin
			rem_q <= '0;
			dvd_q <= NW'(high_q) * NW'(pfdm_pkg::PERCENT);
			dvs_q <= DV'(per_q);
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DV-1:0] : shl[DV-1:0];
			dvd_q <= {dvd_q[NW-2:0], ge};
		end
		if (cmd.save_freq) begin
			freq_q <= (dvd_q > NW'(pfdm_pkg::FREQ_MAX)) ? pfdm_pkg::FREQ_MAX :
				dvd_q[pfdm_pkg::FREQ_W-1:0];
		end
		if (cmd.load_out) begin
			in_range <= ok_q;
			if (ok_q) begin
				high_ticks   <= pfdm_pkg::TICK_W'(high_q);
				period_ticks <= pfdm_pkg::TICK_W'(per_q);
				freq_khz     <= freq_q;
				duty_percent <= dvd_q[pfdm_pkg::DUTY_W-1:0];
			end else begin
				high_ticks   <= '0;
				period_ticks <= '0;
				freq_khz     <= '0;
				duty_percent <= '0;
			end
		end
	end

endmodule
`default_nettype wire
